FILE: design/coo_to_csc_builder_assert.svh
// Assertion macros shared by the RTL files.
// Each expects clk and rst_n in the scope where it is used.
`ifndef COO_TO_CSC_BUILDER_ASSERT_SVH
`define COO_TO_CSC_BUILDER_ASSERT_SVH

// Same-cycle implication.
`define CTCB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctcb assertion failed");

// Next-cycle implication.
`define CTCB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctcb assertion failed");

`endif

FILE: design/ctcb_pkg.sv
package ctcb_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EDGES_DEF    = 1024;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'd1;

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_READ_OFF = 2'd1;
  localparam logic [1:0] CMD_READ_ROW = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DST_RANGE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_INDEX     = 3'd3;
  localparam logic [2:0] ST_NOT_BUILT = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic clr;
    logic cnt_a;
    logic cnt_b;
    logic cnt_c;
    logic pfx_a;
    logic pfx_b;
    logic sct_a;
    logic sct_b;
    logic sct_c;
    logic rd_done;
    logic build_done;
  } ctcb_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic need_read;
    logic need_build;
    logic idx_at_mv;
    logic idx_at_end;
    logic edges_zero;
  } ctcb_sts_t;

endpackage

FILE: design/ctcb_if.sv
interface ctcb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] src_vertex;
  logic [31:0] dst_vertex;
  logic        last_edge;
  logic [10:0] read_index;

  modport source (output valid, command, src_vertex, dst_vertex, last_edge, read_index,
                  input ready);
  modport sink (input valid, command, src_vertex, dst_vertex, last_edge, read_index,
                output ready);
endinterface

interface ctcb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [2:0]  status;

  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

FILE: design/ctcb_ram.sv
module ctcb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/ctcb_ctrl.sv
`include "coo_to_csc_builder_assert.svh"

module ctcb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ctcb_pkg::ctcb_sts_t sts,
  output ctcb_pkg::ctcb_cmd_t cmd
);
  import ctcb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_CLR, S_CNT_A, S_CNT_B, S_CNT_C,
    S_PFX_A, S_PFX_B, S_SCT_A, S_SCT_B, S_SCT_C, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;

  // Decode commands and next state
  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (sts.need_build) begin
            state_nxt = S_CLR;
          end else if (sts.need_read) begin
            state_nxt = S_RD_WAIT;
          end
        end
      end
      S_RD_WAIT: begin
        cmd.rd_done = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.idx_at_mv) begin
          state_nxt = sts.edges_zero ? S_PFX_A : S_CNT_A;
        end
      end
      S_CNT_A: begin
        cmd.cnt_a = 1'b1;
        state_nxt = S_CNT_B;
      end
      S_CNT_B: begin
        cmd.cnt_b = 1'b1;
        state_nxt = S_CNT_C;
      end
      S_CNT_C: begin
        cmd.cnt_c = 1'b1;
        state_nxt = sts.idx_at_end ? S_PFX_A : S_CNT_A;
      end
      S_PFX_A: begin
        cmd.pfx_a = 1'b1;
        state_nxt = S_PFX_B;
      end
      S_PFX_B: begin
        cmd.pfx_b = 1'b1;
        if (sts.idx_at_mv) begin
          state_nxt = sts.edges_zero ? S_FIN : S_SCT_A;
        end else begin
          state_nxt = S_PFX_A;
        end
      end
      S_SCT_A: begin
        cmd.sct_a = 1'b1;
        state_nxt = S_SCT_B;
      end
      S_SCT_B: begin
        cmd.sct_b = 1'b1;
        state_nxt = S_SCT_C;
      end
      S_SCT_C: begin
        cmd.sct_c = 1'b1;
        state_nxt = sts.idx_at_end ? S_FIN : S_SCT_A;
      end
      S_FIN: begin
        cmd.build_done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CTCB_ASSERT_NXT(a_build_starts, cmd.accept && sts.need_build, state_r == S_CLR)
  `CTCB_ASSERT_NXT(a_read_one_wait, state_r == S_RD_WAIT, state_r == S_IDLE)
  `CTCB_ASSERT_NXT(a_fin_returns, state_r == S_FIN, state_r == S_IDLE)
  `CTCB_ASSERT_IMP(a_no_accept_busy, in_ready, !cmd.clr && !cmd.sct_c && !cmd.rd_done)

endmodule

FILE: design/ctcb_datapath.sv
`include "coo_to_csc_builder_assert.svh"

module ctcb_datapath #(
  parameter int MAX_VERTICES = ctcb_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = ctcb_pkg::MAX_EDGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ctcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctcb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]                     in_command,
  input  logic [31:0]                    in_src_vertex,
  input  logic [31:0]                    in_dst_vertex,
  input  logic                           in_last_edge,
  input  logic [10:0]                    in_read_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_read_value,
  output logic [2:0]                     out_status,
  input  ctcb_pkg::ctcb_cmd_t            cmd,
  output ctcb_pkg::ctcb_sts_t            sts
);
  import ctcb_pkg::*;

  localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int OAW = $clog2(MAX_VERTICES + 1);
  localparam int OW  = $clog2(MAX_EDGES + 1);
  localparam int MAXD = (MAX_VERTICES > MAX_EDGES) ? MAX_VERTICES : MAX_EDGES;
  localparam int IW  = $clog2(MAXD + 1);
  localparam logic [31:0] MV32 = 32'(MAX_VERTICES);
  localparam logic [31:0] ME32 = 32'(MAX_EDGES);

  logic [31:0]    base_r;
  logic [10:0]    vcount_r;
  logic [ECW-1:0] edges_r;
  logic           built_r;
  logic [IW-1:0]  idx_r;
  logic [OW-1:0]  acc_r;
  logic [VW-1:0]  d_r;
  logic [31:0]    src_r;
  logic [2:0]     pend_r;
  logic           rd_sel_r;
  logic           out_valid_r;
  logic [31:0]    out_value_r;
  logic [2:0]     out_status_r;

  logic [31:0]    src_rdata;
  logic [VW-1:0]  dst_rdata;
  logic [OW-1:0]  off_rdata;
  logic [OW-1:0]  cur_rdata;
  logic [31:0]    row_rdata;

  logic [31:0]    active32, local32, idx32, eff32, idxr32;
  logic [ECW-1:0] eff_edges;
  logic [2:0]     load_status, rd_status;
  logic           load_ok, is_load, is_read;
  logic [OW-1:0]  acc_nxt;
  logic [31:0]    dnext32, dreg32;

  logic           off_we, cur_we, row_we, edge_we;
  logic [OAW-1:0] off_waddr, off_raddr;
  logic [OW-1:0]  off_wdata, cur_wdata;
  logic [VW-1:0]  cur_waddr;

  // Decode the item at the input
  always_comb begin
    active32  = (32'(vcount_r) > MV32) ? MV32 : 32'(vcount_r);
    local32   = in_dst_vertex - base_r;
    idx32     = 32'(in_read_index);
    idxr32    = 32'(idx_r);
    eff_edges = built_r ? '0 : edges_r;
    eff32     = 32'(eff_edges);
    is_load   = (in_command == CMD_LOAD);
    is_read   = 1'b0;
    load_ok   = 1'b0;
    if (local32 >= active32) begin
      load_status = ST_DST_RANGE;
    end else if (eff32 >= ME32) begin
      load_status = ST_FULL;
    end else begin
      load_status = ST_OK;
      load_ok     = 1'b1;
    end
    case (in_command)
      CMD_READ_OFF: begin
        if (!built_r) begin
          rd_status = ST_NOT_BUILT;
        end else if (idx32 > active32) begin
          rd_status = ST_INDEX;
        end else begin
          rd_status = ST_OK;
          is_read   = 1'b1;
        end
      end
      CMD_READ_ROW: begin
        if (!built_r) begin
          rd_status = ST_NOT_BUILT;
        end else if (idx32 >= 32'(edges_r) || idx32 >= ME32) begin
          rd_status = ST_INDEX;
        end else begin
          rd_status = ST_OK;
          is_read   = 1'b1;
        end
      end
      default: rd_status = ST_INDEX;
    endcase
    acc_nxt = acc_r + off_rdata;
    dnext32 = 32'(dst_rdata) + 32'd1;
    dreg32  = 32'(d_r) + 32'd1;
  end

  // Steer memory ports
  always_comb begin
    edge_we   = cmd.accept && is_load && load_ok;
    off_we    = cmd.clr || cmd.cnt_c || cmd.pfx_b;
    off_waddr = idx_r[OAW-1:0];
    off_wdata = '0;
    if (cmd.cnt_c) begin
      off_waddr = dreg32[OAW-1:0];
      off_wdata = off_rdata + OW'(1);
    end else if (cmd.pfx_b) begin
      off_wdata = acc_nxt;
    end
    off_raddr = cmd.cnt_b ? dnext32[OAW-1:0] :
                cmd.pfx_a ? idx_r[OAW-1:0] : idx32[OAW-1:0];
    cur_we    = (cmd.pfx_b && (idxr32 < MV32)) || cmd.sct_c;
    cur_waddr = cmd.sct_c ? d_r : idx_r[VW-1:0];
    cur_wdata = cmd.sct_c ? (cur_rdata + OW'(1)) : acc_nxt;
    row_we    = cmd.sct_c;
  end

  ctcb_ram #(.WIDTH(32), .DEPTH(MAX_EDGES)) u_src_ram (
    .clk(clk), .we(edge_we), .waddr(eff_edges[EAW-1:0]),
    .wdata(in_src_vertex), .raddr(idx_r[EAW-1:0]), .rdata(src_rdata)
  );

  ctcb_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_dst_ram (
    .clk(clk), .we(edge_we), .waddr(eff_edges[EAW-1:0]),
    .wdata(local32[VW-1:0]), .raddr(idx_r[EAW-1:0]),
    .rdata(dst_rdata)
  );

  ctcb_ram #(.WIDTH(OW), .DEPTH(MAX_VERTICES + 1)) u_off_ram (
    .clk(clk), .we(off_we), .waddr(off_waddr),
    .wdata(off_wdata), .raddr(off_raddr), .rdata(off_rdata)
  );

  ctcb_ram #(.WIDTH(OW), .DEPTH(MAX_VERTICES)) u_cur_ram (
    .clk(clk), .we(cur_we), .waddr(cur_waddr),
    .wdata(cur_wdata), .raddr(dst_rdata), .rdata(cur_rdata)
  );

  ctcb_ram #(.WIDTH(32), .DEPTH(MAX_EDGES)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(cur_rdata[EAW-1:0]),
    .wdata(src_r), .raddr(idx32[EAW-1:0]), .rdata(row_rdata)
  );

  // Status to controller
  always_comb begin
    sts.out_free   = !out_valid_r || out_ready;
    sts.need_read  = !is_load && is_read;
    sts.need_build = is_load && in_last_edge;
    sts.idx_at_mv  = (idxr32 == MV32);
    sts.idx_at_end = ((idxr32 + 32'd1) == 32'(edges_r));
    sts.edges_zero = (edges_r == '0);
  end

  // Control registers: config, counts, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      vcount_r    <= '0;
      edges_r     <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_VERTEX_BASE) begin
        base_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_VERTEX_COUNT) begin
        vcount_r <= cfg_wdata[10:0];
      end
      if (cmd.accept && is_load) begin
        built_r <= 1'b0;
        edges_r <= load_ok ? (eff_edges + ECW'(1)) : eff_edges;
      end
      if (cmd.build_done) begin
        built_r <= 1'b1;
      end
      if ((cmd.accept && !sts.need_read && !sts.need_build) || cmd.rd_done ||
          cmd.build_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Build walk and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r    <= '0;
      acc_r    <= '0;
      pend_r   <= load_status;
      rd_sel_r <= (in_command == CMD_READ_OFF);
      if (!sts.need_read && !sts.need_build) begin
        out_value_r  <= '0;
        out_status_r <= is_load ? load_status : rd_status;
      end
    end
    if (cmd.clr || cmd.cnt_c || cmd.pfx_b || cmd.sct_c) begin
      if ((cmd.clr || cmd.pfx_b) ? sts.idx_at_mv : sts.idx_at_end) begin
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + IW'(1);
      end
    end
    if (cmd.pfx_b) begin
      acc_r <= acc_nxt;
    end
    if (cmd.cnt_b || cmd.sct_b) begin
      d_r   <= dst_rdata;
      src_r <= src_rdata;
    end
    if (cmd.rd_done) begin
      out_value_r  <= rd_sel_r ? 32'(off_rdata) : row_rdata;
      out_status_r <= ST_OK;
    end
    if (cmd.build_done) begin
      out_value_r  <= '0;
      out_status_r <= pend_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

  `CTCB_ASSERT_NXT(a_built_after_fin, cmd.build_done, built_r && out_valid_r)
  `CTCB_ASSERT_IMP(a_edges_bound, 1'b1, 32'(edges_r) <= ME32)

endmodule

FILE: design/coo_to_csc_builder.sv
// COO to CSC index builder.
// in_ch carries one item per handshake: a load (command 0) stores one edge,
// a read (command 1 or 2) fetches a column offset or a row index. out_ch
// returns exactly one item (read_value, status) for every input item.
// cfg_we/cfg_index/cfg_wdata write vertex_base (index 0) and vertex_count
// (index 1); write them only while the block is idle.
// A plain load or an error read answers in the cycle after acceptance,
// a good read after a wait state (registered memory read). A load with last_edge set
// runs the build first: an offset clear and a prefix walk over the MAX_VERTICES+1
// offsets, then count and scatter passes over the stored edges (each pass
// a read-modify-write through one memory port), and then answers.
// One item is in flight at a time; a new item is taken once the result
// register is empty or being drained. With the receiver always ready, plain loads
// and error reads go one per cycle; a good read is answered before the next
// item is taken. Reset (rst_n low, synchronous) empties the edge list and
// clears the built and output valid flags; memories need no clearing pass.
// When out_ch stalls, the result holds and in_ch.ready stays low.
module coo_to_csc_builder #(
  parameter int MAX_VERTICES = ctcb_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = ctcb_pkg::MAX_EDGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ctcb_in_if.sink                         in_ch,
  ctcb_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ctcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctcb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ctcb_pkg::*;

  ctcb_cmd_t cmd;
  ctcb_sts_t sts;

  ctcb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  ctcb_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_command(in_ch.command), .in_src_vertex(in_ch.src_vertex),
    .in_dst_vertex(in_ch.dst_vertex), .in_last_edge(in_ch.last_edge),
    .in_read_index(in_ch.read_index),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_read_value(out_ch.read_value), .out_status(out_ch.status),
    .cmd(cmd), .sts(sts)
  );

endmodule
